### src/btda_pkg.sv
// ---------------------------------------------------------------------------
// btda_pkg: shared types and constants for the binary-to-decimal converter
// Holds the digit counts, the ASCII base code and the sequencer state type.
// ---------------------------------------------------------------------------
package btda_pkg;

    // Width of the binary input value.
    localparam int BIN_W = 32;

    // Number of decimal digits needed for a 32-bit value.
    localparam int DIGITS = 10;

    // Width of the packed BCD result.
    localparam int BCD_W = 4 * DIGITS;

    // Width of an index that selects one digit.
    localparam int IDX_W = $clog2(DIGITS);

    // Width of the shift step counter.
    localparam int STEP_W = $clog2(BIN_W);

    // Index of the final shift step.
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BIN_W - 1);

    // ASCII code of the character '0'.
    localparam logic [5:0] CHAR_BASE = 6'd48;

    // Top level sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } btda_state_t;

    // One decimal digit.
    typedef logic [3:0] nibble_t;

endpackage

### src/btda_dabble.sv
// ---------------------------------------------------------------------------
// btda_dabble: iterative shift-and-add-3 conversion unit
// Converts a 32-bit binary value into ten BCD digits, one bit per cycle.
// ---------------------------------------------------------------------------
module btda_dabble
    import btda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [BIN_W-1:0]     value,
    output logic                 done,
    output logic [BCD_W-1:0]     bcd
);

    logic [BIN_W-1:0]  bin_reg;
    logic [BIN_W-1:0]  bin_next;
    logic [BCD_W-1:0]  bcd_reg;
    logic [BCD_W-1:0]  bcd_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [BCD_W-1:0]  adjusted;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Step control: load on start, then one shift per cycle.
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adjusted[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next  = {bin_reg[BIN_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

### src/btda_emit.sv
// ---------------------------------------------------------------------------
// btda_emit: digit emitter
// Drops leading zeros and sends the digits as ASCII beats, most significant
// first, through a registered output stage.
// ---------------------------------------------------------------------------
module btda_emit
    import btda_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [BCD_W-1:0] bcd,
    output logic             done,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [5:0]       digit_char,
    output logic             last
);

    nibble_t           dig_reg [DIGITS];
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              active_reg;
    logic              active_next;
    logic              valid_reg;
    logic              valid_next;
    logic [5:0]        char_reg;
    logic [5:0]        char_next;
    logic              last_reg;
    logic              last_next;
    logic [IDX_W-1:0]  lead;
    logic              slot_free;

    // Position of the most significant non-zero digit; zero for a zero value.
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd[4*i +: 4] != 4'd0)
            begin
                lead = IDX_W'(i);
            end
        end
    end

    assign slot_free = !valid_reg || !out_stall;

    // Output stage and digit walk.
    always_comb
    begin
        idx_next    = idx_reg;
        active_next = active_reg;
        valid_next  = valid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (load)
        begin
            idx_next    = lead;
            active_next = 1'b1;
        end
        else if (slot_free)
        begin
            if (active_reg)
            begin
                valid_next = 1'b1;
                char_next  = CHAR_BASE + {2'b00, dig_reg[idx_reg]};
                last_next  = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            idx_reg    <= idx_next;
        end
    end

    // Digit store and output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                dig_reg[i] <= bcd[4*i +: 4];
            end
        end
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign done       = !active_reg && !valid_reg;
    assign out_valid  = valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

endmodule

### src/binary_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii: 32-bit binary to decimal ASCII text
// Converts one unsigned value into its decimal digits as ASCII characters.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, value) takes one 32-bit unsigned
// beat. The output channel (out_valid, out_stall, digit_char, last) then
// delivers one beat per decimal digit, most significant first, with no
// leading zeros; zero gives the single character '0'. last marks the final
// digit of each number.
// The shift-and-add-3 unit converts the value, the sequencer hands the BCD
// digits to the emitter, and the output register puts out the first digit;
// then one digit per cycle while out_stall is low. in_stall stays high from
// the accepted input until the last digit has been taken and the sequencer
// is idle.
// A stall on the output freezes the current beat and the digit walk; no
// digit is lost or repeated.
// Reset clears the sequencer and the output valid; nothing is kept from one
// number to the next.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii
    import btda_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [BIN_W-1:0] value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [5:0]       digit_char,
    output logic             last
);

    btda_state_t      state_reg;
    btda_state_t      state_next;
    logic             conv_start;
    logic             conv_done;
    logic             emit_load;
    logic             emit_done;
    logic [BCD_W-1:0] bcd;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_stall   = 1'b1;
        conv_start = 1'b0;
        emit_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                conv_start = in_valid;
            end
            ST_CONV:
            begin
                emit_load = conv_done;
            end
            ST_EMIT:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Shift-and-add-3 conversion unit.
    btda_dabble u_dabble
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .value (value),
        .done  (conv_done),
        .bcd   (bcd)
    );

    // Digit emitter with output register.
    btda_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit_load),
        .bcd        (bcd),
        .done       (emit_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule
